### src/slfr_pkg.sv
// Shared types and codes for the sync/length frame receiver.
package slfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_RESET = 2'd1,
    OP_STOP  = 2'd2,
    OP_SEND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_DISABLED  = 2'd1,
    MODE_HEADER    = 2'd2,
    MODE_RECEIVING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_IGNORED     = 3'd0,
    KIND_SYNC_OK     = 3'd1,
    KIND_SYNC_MISS   = 3'd2,
    KIND_LEN_LOW     = 3'd3,
    KIND_HEADER_DONE = 3'd4,
    KIND_PAYLOAD     = 3'd5,
    KIND_CONTROL     = 3'd6
  } kind_t;

  // Header byte positions
  typedef enum logic [1:0] {
    HP_SYNC1  = 2'd0,
    HP_SYNC2  = 2'd1,
    HP_LENLO  = 2'd2,
    HP_LENHI  = 2'd3
  } hpos_t;

  // Register indexes (byte address = 4 * index)
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // Sync byte values from the register file
  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
  } sync_cfg_t;

  // One result item
  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  data;
    logic [LenW-1:0]   payload_index;
    logic              last;
    mode_t             mode_now;
    logic [LenW-1:0]   frame_length;
  } res_t;

endpackage

### src/slfr_cfg.sv
// APB register file holding the two sync byte values.
module slfr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slfr_pkg::AddrW-1:0]   paddr,
  input  logic [slfr_pkg::DataW-1:0]   pwdata,
  output logic [slfr_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output slfr_pkg::sync_cfg_t          cfg
);
  import slfr_pkg::*;

  logic [ByteW-1:0] sync_first_r;
  logic [ByteW-1:0] sync_second_r;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= '0;
      sync_second_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[ByteW-1:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SYNC_FIRST:  prdata[ByteW-1:0] = sync_first_r;
      REG_SYNC_SECOND: prdata[ByteW-1:0] = sync_second_r;
      default: ;
    endcase
  end

  assign cfg.sync_first  = sync_first_r;
  assign cfg.sync_second = sync_second_r;

endmodule

### src/slfr_deframe.sv
// Frame state machine: mode, header position, length and payload count.
module slfr_deframe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  slfr_pkg::op_t                op,
  input  logic [slfr_pkg::ByteW-1:0]   rx_byte,
  input  slfr_pkg::sync_cfg_t          cfg,
  output slfr_pkg::res_t               res
);
  import slfr_pkg::*;

  mode_t            mode_r,    mode_nxt;
  hpos_t            hpos_r,    hpos_nxt;
  logic [ByteW-1:0] len_lo_r,  len_lo_nxt;
  logic [LenW-1:0]  exp_len_r, exp_len_nxt;
  logic [LenW-1:0]  count_r,   count_nxt;
  logic [LenW-1:0]  count_inc;
  logic [LenW-1:0]  hdr_len;
  logic             count_done;
  logic             count_final;

  assign count_inc   = count_r + LenW'(1);
  assign hdr_len     = {rx_byte, len_lo_r};
  assign count_done  = (count_r >= exp_len_r);
  assign count_final = (count_inc >= exp_len_r);

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    hpos_nxt    = hpos_r;
    len_lo_nxt  = len_lo_r;
    exp_len_nxt = exp_len_r;
    count_nxt   = count_r;
    unique case (op)
      OP_RESET: mode_nxt = MODE_IDLE;
      OP_STOP:  mode_nxt = MODE_DISABLED;
      OP_SEND: begin
        if (mode_r == MODE_IDLE) begin
          mode_nxt    = MODE_HEADER;
          hpos_nxt    = HP_SYNC1;
          exp_len_nxt = '0;
          count_nxt   = '0;
        end
      end
      OP_BYTE: begin
        if (mode_r == MODE_HEADER) begin
          unique case (hpos_r)
            HP_SYNC1: begin
              if (rx_byte == cfg.sync_first) hpos_nxt = HP_SYNC2;
            end
            HP_SYNC2: begin
              hpos_nxt = (rx_byte == cfg.sync_second) ? HP_LENLO : HP_SYNC1;
            end
            HP_LENLO: begin
              len_lo_nxt = rx_byte;
              hpos_nxt   = HP_LENHI;
            end
            HP_LENHI: begin
              exp_len_nxt = hdr_len;
              hpos_nxt    = HP_SYNC1;
              count_nxt   = '0;
              mode_nxt    = (hdr_len == '0) ? MODE_IDLE : MODE_RECEIVING;
            end
            default: ;
          endcase
        end else if (mode_r == MODE_RECEIVING) begin
          if (count_done) begin
            mode_nxt = MODE_IDLE;
          end else begin
            count_nxt = count_inc;
            if (count_final) mode_nxt = MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    res               = '0;
    res.kind          = KIND_IGNORED;
    res.mode_now      = mode_nxt;
    res.frame_length  = exp_len_nxt;
    unique case (op)
      OP_RESET, OP_STOP: res.kind = KIND_CONTROL;
      OP_SEND: begin
        if (mode_r == MODE_IDLE) res.kind = KIND_CONTROL;
      end
      OP_BYTE: begin
        if (mode_r == MODE_HEADER) begin
          unique case (hpos_r)
            HP_SYNC1: res.kind = (rx_byte == cfg.sync_first) ? KIND_SYNC_OK : KIND_SYNC_MISS;
            HP_SYNC2: res.kind = (rx_byte == cfg.sync_second) ? KIND_SYNC_OK : KIND_SYNC_MISS;
            HP_LENLO: res.kind = KIND_LEN_LOW;
            HP_LENHI: begin
              res.kind = KIND_HEADER_DONE;
              res.last = (hdr_len == '0);
            end
            default: ;
          endcase
        end else if (mode_r == MODE_RECEIVING && !count_done) begin
          res.kind          = KIND_PAYLOAD;
          res.data          = rx_byte;
          res.payload_index = count_r;
          res.last          = count_final;
        end
      end
      default: ;
    endcase
  end

  // Advance state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hpos_r    <= HP_SYNC1;
      len_lo_r  <= '0;
      exp_len_r <= '0;
      count_r   <= '0;
    end else if (go) begin
      mode_r    <= mode_nxt;
      hpos_r    <= hpos_nxt;
      len_lo_r  <= len_lo_nxt;
      exp_len_r <= exp_len_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

### src/slfr_outreg.sv
// Result register with valid/stall handshake.
module slfr_outreg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  slfr_pkg::res_t               res,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output slfr_pkg::res_t               res_q
);
  import slfr_pkg::*;

  logic valid_r;
  res_t res_r;

  // Room for a new item when empty or when the held one leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

endmodule

### src/sync_length_frame_receiver.sv
// Top level of the sync/length frame receiver.
//
//  port group   direction  handshake            payload
//  in_*         input      in_valid / in_stall  in_op, in_rx_byte
//  out_*        output     out_valid/out_stall  kind, data, payload_index, last, mode_now,
//                                               frame_length
//  APB          input      psel/penable/pready  sync_first @0x0, sync_second @0x4
//
// Each item's result passes through the input register, then the result register,
// before it shows on out_*; one item per cycle is sustained while out_stall is
// low, set by the single state update in the frame state machine.
// Synchronous active-low reset clears mode, counters and both valid flags.
// A stall on the output holds the result register and backs up into in_stall.
module sync_length_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_data,
  output logic [15:0]                 out_payload_index,
  output logic                        out_last,
  output logic [1:0]                  out_mode_now,
  output logic [15:0]                 out_frame_length,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import slfr_pkg::*;

  logic             in_valid_r;
  op_t              in_op_r;
  logic [ByteW-1:0] in_byte_r;
  logic             out_free;
  logic             go;
  sync_cfg_t        cfg;
  res_t             res;
  res_t             res_q;

  assign go       = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= op_t'(in_op);
      in_byte_r <= in_rx_byte;
    end
  end

  slfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slfr_deframe u_deframe (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .op      (in_op_r),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  slfr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_valid_r),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign out_kind          = 3'(res_q.kind);
  assign out_data          = res_q.data;
  assign out_payload_index = res_q.payload_index;
  assign out_last          = res_q.last;
  assign out_mode_now      = 2'(res_q.mode_now);
  assign out_frame_length  = res_q.frame_length;

endmodule

### src/slfr_chk.sv
// Port-level checks for the frame receiver, bound to the top level.
module slfr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_data,
  input logic [15:0] out_payload_index,
  input logic        out_last,
  input logic [1:0]  out_mode_now,
  input logic [15:0] out_frame_length
);
  import slfr_pkg::*;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_data)
      && $stable(out_payload_index) && $stable(out_last) && $stable(out_frame_length))
    else $error("stalled result changed");

  // Data and index only on payload items
  a_nonpay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_data == '0 && out_payload_index == '0)
    else $error("data or index set on non-payload item");

  // Last ends the frame
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_kind == KIND_PAYLOAD || out_kind == KIND_HEADER_DONE)
      && out_mode_now == MODE_IDLE)
    else $error("last without frame end");

  // Header done picks mode from the length
  a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER_DONE |->
      out_last == (out_frame_length == '0)
      && out_mode_now == ((out_frame_length == '0) ? MODE_IDLE : MODE_RECEIVING))
    else $error("header done inconsistent with length");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sync_length_frame_receiver slfr_chk u_slfr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_data          (out_data),
  .out_payload_index (out_payload_index),
  .out_last          (out_last),
  .out_mode_now      (out_mode_now),
  .out_frame_length  (out_frame_length)
);
